// File: rtl/hism_pkg.sv
`timescale 1ns / 1ps
package hism_pkg;

    // Element width and default block length
    localparam int VAL_W     = 32;
    localparam int COUNT_DEF = 16;

    typedef logic signed [VAL_W-1:0] t_val;

    // Contents of one cell as seen by its neighbors
    typedef struct packed {
        logic vld;
        t_val val;
    } t_cell_link;

    // Per-chain command from the sequencer
    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctl;

endpackage

// File: rtl/hism_in_if.sv
`timescale 1ns / 1ps
interface hism_in_if import hism_pkg::*; ();
    logic valid;
    logic ready;
    t_val value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// File: rtl/hism_out_if.sv
`timescale 1ns / 1ps
interface hism_out_if import hism_pkg::*; ();
    logic valid;
    logic ready;
    t_val sorted_value;
    logic last;

    modport source (output valid, output sorted_value, output last, input ready);
    modport sink   (input valid, input sorted_value, input last, output ready);
endinterface

// File: rtl/hism_cell.sv
`timescale 1ns / 1ps
module hism_cell import hism_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctl  i_ctl,
    input  t_val       i_din,
    input  t_cell_link i_left,
    input  t_cell_link i_right,
    output t_cell_link o_link
);

    logic r_vld;
    t_val r_val;
    logic n_vld;
    t_val n_val;
    logic w_before_me;
    logic w_before_left;

    // New word sorts ahead of this cell (an empty cell acts as +infinity)
    assign w_before_me   = !r_vld || (i_din < r_val);
    assign w_before_left = !i_left.vld || (i_din < i_left.val);

    // Pop shifts toward the head; insert shifts the tail away and drops the word in
    always_comb begin
        n_vld = r_vld;
        n_val = r_val;
        if (i_ctl.pop) begin
            n_vld = i_right.vld;
            n_val = i_right.val;
        end else if (i_ctl.ins && w_before_me) begin
            if (w_before_left) begin
                n_vld = i_left.vld;
                n_val = i_left.val;
            end else begin
                n_vld = 1'b1;
                n_val = i_din;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_link = '{vld: r_vld, val: r_val};

endmodule

// File: rtl/hism_chain.sv
`timescale 1ns / 1ps
module hism_chain import hism_pkg::*; #(
    parameter int DEPTH = COUNT_DEF / 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctl  i_ctl,
    input  t_val       i_din,
    output t_cell_link o_head
);

    t_cell_link w_link [DEPTH];

    // Cell 0 sees a full left neighbor holding the minimum, so nothing passes it
    localparam t_cell_link HEAD_GUARD = '{vld: 1'b1, val: {1'b1, {(VAL_W-1){1'b0}}}};
    localparam t_cell_link TAIL_GUARD = '{vld: 1'b0, val: '0};

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_link w_left;
        t_cell_link w_right;

        if (g == 0) begin : g_head
            assign w_left = HEAD_GUARD;
        end else begin : g_mid_l
            assign w_left = w_link[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right = TAIL_GUARD;
        end else begin : g_mid_r
            assign w_right = w_link[g+1];
        end

        hism_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (i_ctl),
            .i_din   (i_din),
            .i_left  (w_left),
            .i_right (w_right),
            .o_link  (w_link[g])
        );
    end

    assign o_head = w_link[0];

endmodule

// File: rtl/half_insertion_sort_merge_top.sv
`timescale 1ns / 1ps
// Sorts blocks of COUNT signed 32-bit words.
// Input channel i_in: one word per handshake. The first COUNT/2 words of a
// block go into the lower insertion chain, the rest into the upper chain.
// Each chain is a row of cells kept in ascending order; a word is inserted
// in the cycle it is accepted.
// After the COUNT-th word the input is held not ready and the two chain
// heads are merged: each cycle that o_out is not stalled, the smaller head
// is popped, every cell of that chain shifts one place toward its head, and
// the word goes to the output register. Output channel o_out carries
// sorted_value and last, with last set on the COUNT-th word of the block.
// The first result is written to the output register once the sequencer
// has entered the merge state after the last word is accepted. A new block
// is not accepted while the previous one is being merged.
// A stall on o_out holds the output register and freezes the merge; the
// next block is accepted as soon as the last word of the merge is in the
// output register. Reset (synchronous, active low) empties both chains
// and returns to loading; no clearing pass is needed.
module half_insertion_sort_merge_top import hism_pkg::*; #(
    parameter int COUNT = COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hism_in_if.sink     i_in,
    hism_out_if.source  o_out
);

    localparam int LOW_N = COUNT / 2;
    localparam int HIGH_N = COUNT - LOW_N;
    localparam int CW = $clog2(COUNT);

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_MERGE = 2'b10
    } t_state;

    t_state      r_state;
    t_state      n_state;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic        r_out_vld;
    t_val        r_out_val;
    logic        r_out_last;

    t_cell_ctl   w_lo_ctl;
    t_cell_ctl   w_hi_ctl;
    t_cell_link  w_lo_head;
    t_cell_link  w_hi_head;
    logic        w_accept;
    logic        w_emit;
    logic        w_take_lo;
    logic        w_last;

    assign i_in.ready = (r_state == ST_LOAD);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_emit     = (r_state == ST_MERGE) && (!r_out_vld || o_out.ready);
    assign w_last     = (r_cnt == CW'(COUNT - 1));

    // Pick the lower head only when strictly smaller; ties go to the upper half
    assign w_take_lo = w_lo_head.vld && (!w_hi_head.vld || (w_lo_head.val < w_hi_head.val));

    // Route inserts by position in the block, pops by merge decision
    always_comb begin
        w_lo_ctl.ins = w_accept && (r_cnt < CW'(LOW_N));
        w_hi_ctl.ins = w_accept && !(r_cnt < CW'(LOW_N));
        w_lo_ctl.pop = w_emit && w_take_lo;
        w_hi_ctl.pop = w_emit && !w_take_lo;
    end

    hism_chain #(.DEPTH(LOW_N)) u_lo_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_lo_ctl),
        .i_din   (i_in.value),
        .o_head  (w_lo_head)
    );

    hism_chain #(.DEPTH(HIGH_N)) u_hi_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_hi_ctl),
        .i_din   (i_in.value),
        .o_head  (w_hi_head)
    );

    // Advance the sequencer: count loaded words, then count emitted words
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_LOAD: begin
                if (w_accept) begin
                    if (w_last) begin
                        n_cnt   = '0;
                        n_state = ST_MERGE;
                    end else begin
                        n_cnt = r_cnt + CW'(1);
                    end
                end
            end
            ST_MERGE: begin
                if (w_emit) begin
                    if (w_last) begin
                        n_cnt   = '0;
                        n_state = ST_LOAD;
                    end else begin
                        n_cnt = r_cnt + CW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_emit) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Hold the output word until taken
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_val  <= w_take_lo ? w_lo_head.val : w_hi_head.val;
            r_out_last <= w_last;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.sorted_value = r_out_val;
    assign o_out.last         = r_out_last;

    // A merge pop always finds a word in one of the chains
    a_emit_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (w_lo_head.vld || w_hi_head.vld))
        else $error("merge popped with both chains empty");

    // The final word of a block returns the sequencer to loading
    a_last_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_last) |=> (r_state == ST_LOAD))
        else $error("sequencer did not return to load after last word");

    // During loading the upper chain fills only after the lower one
    a_lo_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_LOAD) && w_hi_head.vld) |-> w_lo_head.vld)
        else $error("upper chain holds words while lower chain is empty");

    // Both chains are drained when loading of a new block starts
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_LOAD) && (r_cnt == '0)) |-> (!w_lo_head.vld && !w_hi_head.vld))
        else $error("chains not empty at start of block");

endmodule

// File: dv/sorted_run_checker.sv
`timescale 1ns / 1ps
module sorted_run_checker import hism_pkg::*; #(
    parameter int COUNT = COUNT_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    hism_in_if    i_in_mon,
    hism_out_if   i_out_mon,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_words_checked,
    output int    o_blocks_done
);

    localparam int MID = COUNT / 2;

    typedef struct {
        t_val value;
        logic last;
    } t_sorted_word;

    // Block being loaded, and the sorted words still owed by the block
    t_val         block_words [COUNT];
    int           fill_count;
    t_sorted_word sorted_q [$];

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_words_checked = 0;
        o_blocks_done   = 0;
        fill_count      = 0;
    end

    // Insertion-sort one half of the loaded block in place, ascending
    function automatic void sort_half(input int first, input int stop);
        int   pos;
        int   slot;
        t_val word;
        for (pos = first + 1; pos < stop; pos++) begin
            word = block_words[pos];
            slot = pos;
            // check the bound before reading the neighbor
            while (slot > first) begin
                if (!(word < block_words[slot-1])) break;
                block_words[slot] = block_words[slot-1];
                slot--;
            end
            block_words[slot] = word;
        end
    endfunction

    // Sort both halves, then merge them; ties go to the upper half
    function automatic void predict_sorted_block();
        int           lo_idx;
        int           hi_idx;
        int           k;
        t_sorted_word w;
        sort_half(0, MID);
        sort_half(MID, COUNT);
        lo_idx = 0;
        hi_idx = MID;
        for (k = 0; k < COUNT; k++) begin
            if (lo_idx < MID &&
                (hi_idx >= COUNT || block_words[lo_idx] < block_words[hi_idx])) begin
                w.value = block_words[lo_idx];
                lo_idx++;
            end else begin
                w.value = block_words[hi_idx];
                hi_idx++;
            end
            w.last = (k == COUNT - 1);
            sorted_q.push_back(w);
        end
    endfunction

    // Watch both channels; predict on input, compare on output
    always @(posedge i_clk) begin : watch
        t_sorted_word want;
        if (!i_rst_n) begin
            fill_count = 0;
            sorted_q.delete();
        end else begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                block_words[fill_count] = i_in_mon.value;
                fill_count++;
                if (fill_count == COUNT) begin
                    predict_sorted_block();
                    fill_count = 0;
                    o_blocks_done++;
                end
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                o_words_checked++;
                if (sorted_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected word: expected none, got value %0d last %0b",
                             $time, i_out_mon.sorted_value, i_out_mon.last);
                end else begin
                    want = sorted_q.pop_front();
                    if (i_out_mon.sorted_value !== want.value) begin
                        o_fail_count++;
                        $display("%0t: sorted_value: expected %0d, got %0d",
                                 $time, want.value, i_out_mon.sorted_value);
                    end
                    if (i_out_mon.last !== want.last) begin
                        o_fail_count++;
                        $display("%0t: last: expected %0b, got %0b",
                                 $time, want.last, i_out_mon.last);
                    end
                end
            end
        end
        o_pending = sorted_q.size();
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import hism_pkg::*;

    localparam int COUNT       = COUNT_DEF;
    localparam int MID         = COUNT / 2;
    localparam int RAND_BLOCKS = 15;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 200;
    localparam int HOLD_AT     = 40;

    typedef enum int {
        BLK_WIDE,
        BLK_NARROW,
        BLK_RISING,
        BLK_FALLING,
        BLK_FLAT,
        BLK_SWAPPED
    } t_block_kind;

    logic i_clk;
    logic i_rst_n;
    int   cycle_count;
    int   fail_count;
    int   pending;
    int   words_checked;
    int   blocks_done;
    t_val block_buf [COUNT];
    bit   sender_calm;

    hism_in_if  in_ch ();
    hism_out_if out_ch ();

    half_insertion_sort_merge_top #(.COUNT(COUNT)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    sorted_run_checker #(.COUNT(COUNT)) u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_mon        (in_ch),
        .i_out_mon       (out_ch),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_words_checked (words_checked),
        .o_blocks_done   (blocks_done)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort on a hung run
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one word after an optional gap; hold until it is taken
    task automatic offer_word(input t_val word, input int gap);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= word;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_block();
        int i;
        sender_calm = ($urandom_range(0, 3) == 0);
        for (i = 0; i < COUNT; i++)
            offer_word(block_buf[i], sender_calm ? 0 : $urandom_range(0, 4));
    endtask

    // Fill block_buf with a random block of the given shape
    task automatic build_block(input t_block_kind kind);
        int i;
        int base;
        int step;
        t_val flat_word;
        base      = -int'($urandom_range(0, 1000000));
        step      = $urandom_range(0, 3000);
        flat_word = $urandom;
        for (i = 0; i < COUNT; i++) begin
            case (kind)
                BLK_WIDE:    block_buf[i] = $urandom;
                BLK_NARROW:  block_buf[i] = int'($urandom_range(0, 6)) - 3;
                BLK_RISING:  block_buf[i] = base + i * step;
                BLK_FALLING: block_buf[i] = base - i * step;
                BLK_FLAT:    block_buf[i] = flat_word;
                default: begin
                    // lower half all above the upper half
                    if (i < MID)
                        block_buf[i] = 1000000 + int'($urandom_range(0, 1000000));
                    else
                        block_buf[i] = -int'($urandom_range(0, 1000000));
                end
            endcase
        end
    endtask

    // Receiver: random stalls, calm stretches, one long hold
    initial begin : receiver
        int  gap;
        int  words_taken;
        bit  calm;
        out_ch.ready <= 1'b0;
        words_taken = 0;
        calm        = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 4);
            if (words_taken == HOLD_AT)
                gap = LONG_HOLD;
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
            words_taken++;
            if (words_taken % COUNT == 0)
                calm = ($urandom_range(0, 3) == 0);
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        int r;
        int b;
        t_block_kind kind;
        in_ch.valid <= 1'b0;
        in_ch.value <= '0;
        i_rst_n     <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed block: extremes, alternating bits, ties across halves
        block_buf[0]  = 32'sh7FFF_FFFF;
        block_buf[1]  = 32'sh8000_0000;
        block_buf[2]  = 0;
        block_buf[3]  = -1;
        block_buf[4]  = 1;
        block_buf[5]  = 5;
        block_buf[6]  = 32'sh5555_5555;
        block_buf[7]  = 5;
        block_buf[8]  = 32'shAAAA_AAAA;
        block_buf[9]  = 5;
        block_buf[10] = 32'sh8000_0000;
        block_buf[11] = 32'sh7FFF_FFFF;
        block_buf[12] = -2;
        block_buf[13] = 0;
        block_buf[14] = 5;
        block_buf[15] = -1;
        send_block();

        // Random blocks of assorted shapes
        for (b = 0; b < RAND_BLOCKS; b++) begin
            r = $urandom_range(0, 9);
            if (r < 4)       kind = BLK_WIDE;
            else if (r < 6)  kind = BLK_NARROW;
            else if (r == 6) kind = BLK_RISING;
            else if (r == 7) kind = BLK_FALLING;
            else if (r == 8) kind = BLK_FLAT;
            else             kind = BLK_SWAPPED;
            build_block(kind);
            send_block();
        end
        in_ch.valid <= 1'b0;

        // Drain the sorted words, then watch for strays
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Loaded %0d blocks of %0d words and checked %0d sorted words.",
                 blocks_done, COUNT, words_checked);
        $display("Blocks included extremes, ties, presorted, reversed and flat data.");
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
